// ----- src/adhc_pkg.sv -----
// Shared types and constants for the advertising data HID classifier.
// Used by every module of the block; depends on nothing.
package adhc_pkg;

    // Structure type codes of interest.
    localparam logic [7:0] AD_UUID16_MORE = 8'h02;
    localparam logic [7:0] AD_UUID16_ALL  = 8'h03;
    localparam logic [7:0] AD_NAME_SHORT  = 8'h08;
    localparam logic [7:0] AD_NAME_FULL   = 8'h09;

    // 16-bit UUID of the HID service.
    localparam logic [15:0] HID_SERVICE_UUID = 16'h1812;

    // Device codes given in a result word.
    localparam logic [1:0] DEV_UNKNOWN = 2'd0;

    // Name prefixes: one row per prefix, characters in order.
    localparam int NUM_PREFIXES   = 3;
    localparam int MAX_PREFIX_LEN = 11;
    localparam int PREFIX_IDX_W   = $clog2(MAX_PREFIX_LEN);

    localparam logic [7:0] PREFIX_LEN [NUM_PREFIXES] = '{8'd6, 8'd3, 8'd11};

    localparam logic [7:0] PREFIX_CHR [NUM_PREFIXES][MAX_PREFIX_LEN] = '{
        '{8'h58, 8'h69, 8'h61, 8'h6f, 8'h59, 8'h69,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h35, 8'h31, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h6d, 8'h61, 8'h72, 8'h74, 8'h52,
          8'h65, 8'h6d, 8'h6f, 8'h74, 8'h65}
    };

    // One input word as held in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [1:0] device_code;
        logic       hid_found;
    } t_result;

endpackage

// ----- src/adhc_in_if.sv -----
// Input channel of the classifier: one payload byte per word.
// Stands alone; no package needed.
interface adhc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- src/adhc_out_if.sv -----
// Result channel of the classifier: device code and HID flag.
// Stands alone; no package needed.
interface adhc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] device_code;
    logic       hid_found;

    modport source (output valid, output device_code, output hid_found, input ready);
    modport sink   (input valid, input device_code, input hid_found, output ready);
endinterface

// ----- src/adhc_in_reg.sv -----
// Input register of the classifier: captures one word from the input channel.
// Depends on adhc_pkg and adhc_in_if.
module adhc_in_reg
    import adhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    adhc_in_if.sink    i_in,
    input  logic       i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // The register is free when empty or when its word leaves this cycle.
    assign i_in.ready = !r_valid || i_take;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.data_byte <= i_in.data_byte;
            r_item.last_byte <= i_in.last_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- src/adhc_walker.sv -----
// Structure walker: tracks length-type-value structures, checks UUIDs and
// name prefixes, and forms the result on the last byte. Depends on adhc_pkg.
module adhc_walker
    import adhc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    input  logic    i_slot_free,
    output logic    o_take,
    output logic    o_res_valid,
    output t_result o_res
);

    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_field_offset, n_field_offset;
    logic [7:0] r_field_type, n_field_type;
    logic [7:0] r_uuid_low, n_uuid_low;
    logic       r_hid_seen, n_hid_seen;
    logic [1:0] r_device, n_device;
    logic [NUM_PREFIXES-1:0] r_alive, n_alive;

    logic [7:0] k;
    logic       is_uuid;
    logic       is_name;

    // A word moves on unless it carries a result that has nowhere to go.
    assign o_take      = i_valid && (!i_item.last_byte || i_slot_free);
    assign o_res_valid = o_take && i_item.last_byte;

    assign k       = r_field_offset - 8'd1;
    assign is_uuid = (r_field_type == AD_UUID16_MORE) || (r_field_type == AD_UUID16_ALL);
    assign is_name = (r_field_type == AD_NAME_SHORT) || (r_field_type == AD_NAME_FULL);

    // Next state for one byte.
    always_comb begin
        n_bytes_left   = r_bytes_left;
        n_field_offset = r_field_offset;
        n_field_type   = r_field_type;
        n_uuid_low     = r_uuid_low;
        n_hid_seen     = r_hid_seen;
        n_device       = r_device;
        n_alive        = r_alive;

        if (r_bytes_left == 8'd0) begin
            // Length byte; a zero length leaves us expecting another one.
            n_bytes_left   = i_item.data_byte;
            n_field_offset = 8'd0;
        end else begin
            if (r_field_offset == 8'd0) begin
                n_field_type = i_item.data_byte;
                n_alive      = '1;
            end else if (is_uuid) begin
                // Even bytes hold the low half, odd bytes complete the UUID.
                if (!k[0]) begin
                    n_uuid_low = i_item.data_byte;
                end else if ({i_item.data_byte, r_uuid_low} == HID_SERVICE_UUID) begin
                    n_hid_seen = 1'b1;
                end
            end else if (is_name) begin
                // Each live prefix compares its character at this position.
                for (int p = 0; p < NUM_PREFIXES; p++) begin
                    if (r_alive[p] && (k < PREFIX_LEN[p])) begin
                        if (PREFIX_CHR[p][k[PREFIX_IDX_W-1:0]] != i_item.data_byte) begin
                            n_alive[p] = 1'b0;
                        end else if (k == PREFIX_LEN[p] - 8'd1) begin
                            n_device = 2'(p + 1);
                        end
                    end
                end
            end
            n_field_offset = r_field_offset + 8'd1;
            n_bytes_left   = r_bytes_left - 8'd1;
        end
    end

    // The result reflects the state after the last byte is applied.
    assign o_res.hid_found   = n_hid_seen;
    assign o_res.device_code = n_hid_seen ? n_device : DEV_UNKNOWN;

    // State registers; the end of a payload returns them to reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_valid) begin
            r_bytes_left   <= 8'd0;
            r_field_offset <= 8'd0;
            r_field_type   <= 8'd0;
            r_uuid_low     <= 8'd0;
            r_hid_seen     <= 1'b0;
            r_device       <= DEV_UNKNOWN;
            r_alive        <= '1;
        end else if (o_take) begin
            r_bytes_left   <= n_bytes_left;
            r_field_offset <= n_field_offset;
            r_field_type   <= n_field_type;
            r_uuid_low     <= n_uuid_low;
            r_hid_seen     <= n_hid_seen;
            r_device       <= n_device;
            r_alive        <= n_alive;
        end
    end

endmodule

// ----- src/adhc_out_reg.sv -----
// Result register of the classifier: holds one result word for the sink.
// Depends on adhc_pkg and adhc_out_if.
module adhc_out_reg
    import adhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_res,
    output logic       o_slot_free,
    adhc_out_if.source o_out
);

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held word is taken this cycle.
    assign o_slot_free = !r_valid || o_out.ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_load;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_load && o_slot_free) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.device_code = r_res.device_code;
    assign o_out.hid_found   = r_res.hid_found;

endmodule

// ----- src/adv_data_hid_device_classifier_core.sv -----
// Top level of the advertising data HID classifier.
// Depends on adhc_pkg, adhc_in_if, adhc_out_if, adhc_in_reg, adhc_walker, adhc_out_reg.
//
//   Channel   Direction  Word contents
//   i_in      in         data_byte[7:0], last_byte
//   o_out     out        device_code[1:0], hid_found
//
// One byte is accepted every cycle unless a last byte stalls; results are registered.
// The rate is set by the single walker stage between input and result registers.
// Reset clears the structure state and both valid flags; no clearing pass is needed.
// A stalled result only holds back a further last byte; other bytes keep flowing.
module adv_data_hid_device_classifier_core
    import adhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    adhc_in_if.sink    i_in,
    adhc_out_if.source o_out
);

    logic    item_valid;
    t_item   item;
    logic    take;
    logic    slot_free;
    logic    res_valid;
    t_result res;

    // Input register.
    adhc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    // Structure walker and classifier state.
    adhc_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (item_valid),
        .i_item      (item),
        .i_slot_free (slot_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register.
    adhc_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_res       (res),
        .o_slot_free (slot_free),
        .o_out       (o_out)
    );

endmodule

// ----- sim/tb_adv_data_hid_device_classifier_core.sv -----
// Testbench for the advertising data HID classifier: directed and random payloads with a scoreboard.
// Depends on adhc_pkg, adhc_in_if, adhc_out_if and adv_data_hid_device_classifier_core.
module tb_adv_data_hid_device_classifier_core
    import adhc_pkg::*;
();

    typedef logic [7:0] t_byte_q[$];

    // Device codes for the three name prefixes, in prefix order.
    localparam logic [1:0] DEV_NAME_A = 2'd1;
    localparam logic [1:0] DEV_NAME_B = 2'd2;
    localparam logic [1:0] DEV_NAME_C = 2'd3;
    localparam logic [1:0] DEV_OF_NAME [3] = '{DEV_NAME_A, DEV_NAME_B, DEV_NAME_C};

    // Name prefixes, one row per prefix, with their lengths.
    localparam int NAME_LEN [3] = '{6, 3, 11};
    localparam logic [7:0] NAME_CHR [3][11] = '{
        '{8'h58, 8'h69, 8'h61, 8'h6f, 8'h59, 8'h69, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h35, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h6d, 8'h61, 8'h72, 8'h74, 8'h52, 8'h65, 8'h6d, 8'h6f, 8'h74, 8'h65}
    };

    // Tracks the structure walk and holds the results still owed by the block.
    class hid_scoreboard;
        logic [7:0] bytes_left;
        logic [7:0] field_offset;
        logic [7:0] field_type;
        logic [7:0] uuid_low;
        logic       hid_seen;
        logic [1:0] cur_dev;
        logic [2:0] alive;
        t_result    expected_q[$];
        int         errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            bytes_left   = 8'd0;
            field_offset = 8'd0;
            field_type   = 8'd0;
            uuid_low     = 8'd0;
            hid_seen     = 1'b0;
            cur_dev      = DEV_UNKNOWN;
            alive        = 3'b111;
        endfunction

        // A value byte at index k of its structure.
        function void take_value(logic [7:0] b, logic [7:0] k);
            if (field_type == AD_UUID16_MORE || field_type == AD_UUID16_ALL) begin
                if (!k[0]) begin
                    uuid_low = b;
                end else if ({b, uuid_low} == HID_SERVICE_UUID) begin
                    hid_seen = 1'b1;
                end
            end else if (field_type == AD_NAME_SHORT || field_type == AD_NAME_FULL) begin
                for (int p = 0; p < 3; p++) begin
                    if (alive[p] && k < NAME_LEN[p]) begin
                        if (NAME_CHR[p][k] != b) begin
                            alive[p] = 1'b0;
                        end else if (k + 1 == NAME_LEN[p]) begin
                            cur_dev = DEV_OF_NAME[p];
                        end
                    end
                end
            end
        endfunction

        // Called for every accepted input word.
        function void note_byte(logic [7:0] b, logic last);
            t_result r;
            if (bytes_left == 8'd0) begin
                bytes_left   = b;
                field_offset = 8'd0;
            end else begin
                if (field_offset == 8'd0) begin
                    field_type = b;
                    alive      = 3'b111;
                end else begin
                    take_value(b, field_offset - 8'd1);
                end
                field_offset = field_offset + 8'd1;
                bytes_left   = bytes_left - 8'd1;
            end
            if (last) begin
                r.hid_found   = hid_seen;
                r.device_code = hid_seen ? cur_dev : DEV_UNKNOWN;
                expected_q.push_back(r);
                clear();
            end
        endfunction

        // Called for every accepted result word.
        function void check_result(logic [1:0] dev, logic hid);
            t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result expected none, actual device_code %0d hid_found %0d",
                         $time, dev, hid);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (dev !== want.device_code) begin
                $display("%0t: device_code expected %0d actual %0d",
                         $time, want.device_code, dev);
                errors++;
            end
            if (hid !== want.hid_found) begin
                $display("%0t: hid_found expected %0d actual %0d", $time, want.hid_found, hid);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;
    int   bytes_sent;

    hid_scoreboard sb = new();

    adhc_in_if  in_ch();
    adhc_out_if out_ch();

    adv_data_hid_device_classifier_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Clock, period 20.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Result side: random back-pressure, except during the steady stretch.
    always @(negedge i_clk) begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 26);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.device_code, out_ch.hid_found);
        end
    end

    // Offers one word and waits until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(0, 99) < 26) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_payload(input t_byte_q pl);
        for (int i = 0; i < pl.size(); i++) begin
            send_byte(pl[i], i == pl.size() - 1);
        end
    endtask

    // Appends a 16-bit UUID list, optionally holding the HID service and an odd byte.
    function automatic void add_uuids(ref t_byte_q pl, input logic [7:0] kind,
                                      input int count, input bit with_hid, input bit odd);
        int hid_at;
        logic [15:0] u;
        hid_at = (with_hid && count > 0) ? $urandom_range(0, count - 1) : -1;
        pl.push_back(8'(2 * count + int'(odd) + 1));
        pl.push_back(kind);
        for (int i = 0; i < count; i++) begin
            if (i == hid_at) begin
                u = HID_SERVICE_UUID;
            end else if ($urandom_range(0, 3) == 0) begin
                // Byte-swapped HID value, to catch a wrong byte order.
                u = {HID_SERVICE_UUID[7:0], HID_SERVICE_UUID[15:8]};
            end else begin
                u = 16'($urandom);
            end
            pl.push_back(u[7:0]);
            pl.push_back(u[15:8]);
        end
        if (odd) pl.push_back(8'($urandom));
    endfunction

    // Appends a name field: the first keep characters of prefix p, then extra random bytes.
    function automatic void add_name(ref t_byte_q pl, input logic [7:0] kind, input int p,
                                     input int keep, input int extra);
        pl.push_back(8'(keep + extra + 1));
        pl.push_back(kind);
        for (int i = 0; i < keep; i++) pl.push_back(NAME_CHR[p][i]);
        for (int i = 0; i < extra; i++) pl.push_back(8'($urandom));
    endfunction

    initial begin
        t_byte_q pl;
        int r;
        int nstruct;
        int p;
        int n;

        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'd0;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;
        steady          = 1'b0;
        bytes_sent      = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero-length structure, HID service, then the longest prefix in a complete name.
        pl = '{8'h00};
        add_uuids(pl, AD_UUID16_ALL, 1, 1'b1, 1'b0);
        add_name(pl, AD_NAME_FULL, 2, 11, 0);
        send_payload(pl);

        // Short name holding only part of a prefix, odd UUID list, an unrelated type,
        // then two matching names where the later one wins.
        pl = {};
        add_name(pl, AD_NAME_SHORT, 1, 2, 0);
        add_uuids(pl, AD_UUID16_MORE, 1, 1'b1, 1'b1);
        pl.push_back(8'h02);
        pl.push_back(8'hff);
        pl.push_back(8'h00);
        add_name(pl, AD_NAME_FULL, 0, 6, 1);
        add_name(pl, AD_NAME_SHORT, 1, 3, 0);
        send_payload(pl);

        // Payload ending on a length byte of the largest value.
        send_payload('{8'hff});

        // UUID list cut off by the payload end: HID seen, no name.
        send_payload('{8'h05, AD_UUID16_ALL, 8'h12, 8'h18});

        // Payload ending on a type byte.
        send_payload('{8'h03, AD_NAME_FULL});

        // Random payloads, mostly well formed, some noise, corrupted or truncated.
        while (bytes_sent < 650) begin
            steady = (bytes_sent >= 300 && bytes_sent < 420);
            pl = {};
            r = $urandom_range(0, 99);
            if (r < 10) begin
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++) pl.push_back(8'($urandom));
            end else begin
                nstruct = $urandom_range(1, 5);
                for (int s = 0; s < nstruct; s++) begin
                    r = $urandom_range(0, 99);
                    if (r < 35) begin
                        add_uuids(pl, $urandom_range(0, 1) ? AD_UUID16_ALL : AD_UUID16_MORE,
                                  $urandom_range(0, 4), $urandom_range(0, 1) == 1,
                                  $urandom_range(0, 4) == 0);
                    end else if (r < 70) begin
                        p = $urandom_range(0, 2);
                        add_name(pl, $urandom_range(0, 1) ? AD_NAME_FULL : AD_NAME_SHORT, p,
                                 ($urandom_range(0, 9) < 7) ? NAME_LEN[p]
                                                            : $urandom_range(0, NAME_LEN[p]),
                                 $urandom_range(0, 4));
                    end else if (r < 80) begin
                        pl.push_back(8'h00);
                    end else begin
                        n = $urandom_range(0, 6);
                        pl.push_back(8'(n + 1));
                        pl.push_back(8'($urandom));
                        for (int i = 0; i < n; i++) pl.push_back(8'($urandom));
                    end
                end
                if ($urandom_range(0, 9) == 0) begin
                    pl[$urandom_range(0, pl.size() - 1)] = 8'($urandom);
                end
                if ($urandom_range(0, 99) < 15) begin
                    n = $urandom_range(1, pl.size());
                    pl = pl[0:n-1];
                end
            end
            send_payload(pl);
        end
        steady = 1'b0;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        // Drain the outstanding results, then allow for the pipeline latency.
        for (n = 0; n < 2000 && sb.expected_q.size() != 0; n++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            $display("%0t: %0d results expected but never delivered, actual none",
                     $time, sb.expected_q.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- adv_data_hid_device_classifier_core.f -----
src/adhc_pkg.sv
src/adhc_in_if.sv
src/adhc_out_if.sv
src/adhc_in_reg.sv
src/adhc_walker.sv
src/adhc_out_reg.sv
src/adv_data_hid_device_classifier_core.sv
sim/tb_adv_data_hid_device_classifier_core.sv
